// ===== src/srle_pkg.sv =====
// Shared types and constants for the sprite run-length decoder.
// Used by srle_core and sprite_rle_decoder; depends on nothing else.
package srle_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int MAX_LINES = 1024;

    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int LINE_W = $clog2(MAX_LINES + 1);
    localparam int POS_W  = 10;
    localparam int EXT_W  = 11;
    localparam int CNT_W  = 7;

    localparam logic [POS_W-1:0] POS_MAX = 10'd1023;
    localparam logic [EXT_W-1:0] EXT_MAX = 11'd2047;

    typedef enum logic [1:0] {
        KIND_RUN = 2'd0,
        KIND_EOL = 2'd1,
        KIND_EOI = 2'd2
    } kind_t;

    typedef struct packed {
        logic             valid;
        kind_t            kind;
        logic [POS_W-1:0] x_start;
        logic [POS_W-1:0] line_number;
        logic [7:0]       run_length;
        logic [7:0]       color_index;
        logic             transparent;
        logic [EXT_W-1:0] extent_width;
        logic [EXT_W-1:0] extent_height;
    } result_t;

endpackage

// ===== src/sprite_rle_decoder.sv =====
// Top level of the sprite run-length decoder: input beat register, decoder
// core and output beat register. Depends on srle_pkg and srle_core.
//
// Usage: the slave channel takes one encoded byte per beat in s_tdata; a beat
// with s_tlast high ends the image, its byte is ignored and an end-of-image
// result with the extents follows. The master channel gives at most one
// result per input beat: m_tuser carries the kind (pixel run, end of line,
// end of image) and m_tdata the run and extent fields.
// cfg_wr_en writes cfg_wr_data into the background color register; write it
// only while no beat is in flight.
// Each result passes the input beat register and then the output beat
// register. Throughput: one input beat per cycle while the receiver does
// not stall, set by the single decode step between the two registers.
// Reset clears the decode state, the valid flags of both beat registers and
// the background color. When the receiver stalls, the output beat holds, one
// more input beat is taken into the input register, and s_tready then drops
// until the output beat is taken.
module sprite_rle_decoder import srle_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_image
    output logic        m_tvalid,
    input  logic        m_tready,
    // [9:0] x_start, [19:10] line_number, [27:20] run_length, [35:28] color_index,
    // [36] transparent, [47:37] extent_width, [58:48] extent_height, [63:59] zero
    output logic [63:0] m_tdata,
    output logic [1:0]  m_tuser    // [1:0] kind
);

    logic [7:0] bg_idx_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;
    result_t    core_res;
    logic       advance;
    logic       step_en;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step_en  = in_valid_reg && advance;

    srle_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step_en          (step_en),
        .data_byte        (in_byte_reg),
        .end_of_image     (in_eoi_reg),
        .background_index (bg_idx_reg),
        .result           (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bg_idx_reg    <= 8'd0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                bg_idx_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= step_en && core_res.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eoi_reg  <= s_tlast;
        end
        if (step_en) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tdata  = {5'd0,
                       out_res_reg.extent_height,
                       out_res_reg.extent_width,
                       out_res_reg.transparent,
                       out_res_reg.color_index,
                       out_res_reg.run_length,
                       out_res_reg.line_number,
                       out_res_reg.x_start};

endmodule

// ===== src/srle_core.sv =====
// Decode state and single-step opcode decoder for the sprite run-length decoder.
// Depends on srle_pkg for constants and the result type.
module srle_core import srle_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic [7:0] data_byte,
    input  logic       end_of_image,
    input  logic [7:0] background_index,
    output result_t    result
);

    typedef enum logic [1:0] {
        MODE_OPCODE    = 2'd0,
        MODE_SKIP_LEN  = 2'd1,
        MODE_RUN_COLOR = 2'd2,
        MODE_LITERAL   = 2'd3
    } mode_t;

    localparam int SUM_W = COL_W + 9;

    mode_t             mode_reg,    mode_next;
    logic [CNT_W-1:0]  lit_reg,     lit_next;
    logic [CNT_W-1:0]  pend_reg,    pend_next;
    logic [COL_W-1:0]  col_reg,     col_next;
    logic [LINE_W-1:0] line_reg,    line_next;
    logic [COL_W-1:0]  widest_reg,  widest_next;

    logic [7:0]        run_len;
    logic [SUM_W-1:0]  col_sum;
    logic [COL_W-1:0]  col_sat;
    logic [31:0]       col_ext;
    logic [31:0]       line_ext;
    logic [31:0]       widest_ext;
    logic [POS_W-1:0]  x_clamp;
    logic [POS_W-1:0]  line_clamp;
    logic [EXT_W-1:0]  ew_clamp;
    logic [EXT_W-1:0]  eh_clamp;
    logic [CNT_W-1:0]  count;

    assign count      = data_byte[7:1];
    assign col_ext    = 32'(col_reg);
    assign line_ext   = 32'(line_reg);
    assign widest_ext = 32'(widest_reg);
    assign x_clamp    = (col_ext > 32'(POS_MAX)) ? POS_MAX : col_ext[POS_W-1:0];
    assign line_clamp = (line_ext > 32'(POS_MAX)) ? POS_MAX : line_ext[POS_W-1:0];
    assign ew_clamp   = (widest_ext > 32'(EXT_MAX)) ? EXT_MAX : widest_ext[EXT_W-1:0];
    assign eh_clamp   = (line_ext > 32'(EXT_MAX)) ? EXT_MAX : line_ext[EXT_W-1:0];

    always_comb begin
        unique case (mode_reg)
            MODE_SKIP_LEN:  run_len = data_byte;
            MODE_RUN_COLOR: run_len = {1'b0, pend_reg};
            MODE_LITERAL:   run_len = 8'd1;
            default:        run_len = 8'd0;
        endcase
    end

    assign col_sum = SUM_W'(col_reg) + SUM_W'(run_len);
    assign col_sat = (col_sum > SUM_W'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH) : col_sum[COL_W-1:0];

    always_comb begin
        mode_next   = mode_reg;
        lit_next    = lit_reg;
        pend_next   = pend_reg;
        col_next    = col_reg;
        line_next   = line_reg;
        widest_next = widest_reg;
        result      = '0;
        result.kind = KIND_RUN;

        if (end_of_image) begin
            result.valid         = 1'b1;
            result.kind          = KIND_EOI;
            result.extent_width  = ew_clamp;
            result.extent_height = eh_clamp;
            mode_next   = MODE_OPCODE;
            lit_next    = '0;
            pend_next   = '0;
            col_next    = '0;
            line_next   = '0;
            widest_next = '0;
        end else begin
            unique case (mode_reg)
                MODE_SKIP_LEN: begin
                    mode_next = MODE_OPCODE;
                    if (data_byte != 8'd0) begin
                        result.valid       = 1'b1;
                        result.color_index = background_index;
                        result.transparent = 1'b1;
                    end
                end
                MODE_RUN_COLOR: begin
                    mode_next          = MODE_OPCODE;
                    pend_next          = '0;
                    result.valid       = 1'b1;
                    result.color_index = data_byte;
                end
                MODE_LITERAL: begin
                    result.valid       = 1'b1;
                    result.color_index = data_byte;
                    lit_next = (lit_reg != '0) ? lit_reg - 1'b1 : '0;
                    if (lit_next == '0) begin
                        mode_next = MODE_OPCODE;
                    end
                end
                default: begin
                    if (count == '0) begin
                        if (data_byte[0]) begin
                            mode_next = MODE_SKIP_LEN;
                        end else begin
                            result.valid       = 1'b1;
                            result.kind        = KIND_EOL;
                            result.x_start     = x_clamp;
                            result.line_number = line_clamp;
                            if (line_ext < 32'(MAX_LINES)) begin
                                line_next = line_reg + 1'b1;
                            end
                            col_next = '0;
                        end
                    end else if (data_byte[0]) begin
                        lit_next  = count;
                        mode_next = MODE_LITERAL;
                    end else begin
                        pend_next = count;
                        mode_next = MODE_RUN_COLOR;
                    end
                end
            endcase

            if (result.valid && result.kind == KIND_RUN) begin
                result.x_start     = x_clamp;
                result.line_number = line_clamp;
                result.run_length  = run_len;
                col_next           = col_sat;
                if (col_sat > widest_reg) begin
                    widest_next = col_sat;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_OPCODE;
            lit_reg    <= '0;
            pend_reg   <= '0;
            col_reg    <= '0;
            line_reg   <= '0;
            widest_reg <= '0;
        end else if (step_en) begin
            mode_reg   <= mode_next;
            lit_reg    <= lit_next;
            pend_reg   <= pend_next;
            col_reg    <= col_next;
            line_reg   <= line_next;
            widest_reg <= widest_next;
        end
    end

endmodule
